[rtl/point_grid_hole_fill_assert.svh]
// point_grid_hole_fill_assert.svh: assertion macros for the port checker
// expects clk and rst in scope at the point of use
`ifndef POINT_GRID_HOLE_FILL_ASSERT_SVH
`define POINT_GRID_HOLE_FILL_ASSERT_SVH

// same-cycle implication
`define PGHF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point_grid_hole_fill port check failed");

// next-cycle implication
`define PGHF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("point_grid_hole_fill port check failed");

`endif

[rtl/pghf_pkg.sv]
// pghf_pkg: types, codes and sizes shared by the hole-fill grid block
// no dependencies
package pghf_pkg;

  localparam int GRID_SIZE = 256;
  localparam int GRID_AW   = $clog2(GRID_SIZE);
  localparam int CELL_AW   = 2 * GRID_AW;
  localparam int DIV_W     = 32;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_CLEARED  = 3'd2;
  localparam logic [2:0] ST_OCCUPIED = 3'd3;
  localparam logic [2:0] ST_FILL_X   = 3'd4;
  localparam logic [2:0] ST_FILL_Y   = 3'd5;
  localparam logic [2:0] ST_NO_FILL  = 3'd6;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [23:0] coord_z;
    logic [7:0]         cell_col;
    logic [7:0]         cell_row;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [15:0] fill_x;
    logic signed [15:0] fill_y;
    logic signed [23:0] fill_z;
  } rsp_t;

  // stored point of one cell
  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [23:0] pz;
  } point_t;

endpackage

[rtl/pghf_div.sv]
// pghf_div: unsigned restoring divider, one quotient bit per cycle
// depends on pghf_pkg
module pghf_div import pghf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [DIV_W-1:0] dividend,
  input  logic [7:0]       divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]         dvd;
  logic [7:0]               rem;
  logic [$clog2(DIV_W)-1:0] cnt;
  logic                     run;
  logic [8:0]               rem_s;
  logic                     ge;

  assign rem_s    = {rem, dvd[DIV_W-1]};
  assign ge       = rem_s >= {1'b0, divisor};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == $clog2(DIV_W)'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd <= dividend;
      rem <= '0;
    end else if (run) begin
      // quotient bits shift in where dividend bits leave
      rem <= ge ? 8'(rem_s - {1'b0, divisor}) : rem_s[7:0];
      dvd <= {dvd[DIV_W-2:0], ge};
    end
  end

endmodule

[rtl/point_grid_hole_fill.sv]
// point_grid_hole_fill: grid of binned points with box tracking and hole fill
// depends on pghf_pkg and pghf_div
//
// channel   direction  handshake           payload
// request   in         start & !busy       req (req_t)
// response  out        done, one cycle     rsp (rsp_t)
//
// clear: writes all 65536 cell valid bits, one per cycle; the same pass
// runs after reset, with busy high and no response.
// insert: read, then write back the cell. command 3: rejected straight from idle.
// query: four sequential scans through the one-port valid memory, each cell
// issued, waited on and checked in turn, then two point reads and, for each
// of x, y and z, a multiply and a 32-step division.
// responses cannot be held off; a new command is taken in the done cycle.
module point_grid_hole_fill import pghf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'b0000000000000001,
    S_CLR      = 16'b0000000000000010,
    S_INS_WAIT = 16'b0000000000000100,
    S_INS_WR   = 16'b0000000000001000,
    S_Q_WAIT   = 16'b0000000000010000,
    S_Q_CHK    = 16'b0000000000100000,
    S_SC_ISS   = 16'b0000000001000000,
    S_SC_WAIT  = 16'b0000000010000000,
    S_SC_CHK   = 16'b0000000100000000,
    S_SEL      = 16'b0000001000000000,
    S_LD_WAIT  = 16'b0000010000000000,
    S_LD_CAP   = 16'b0000100000000000,
    S_MUL1     = 16'b0001000000000000,
    S_MUL2     = 16'b0010000000000000,
    S_DIV_GO   = 16'b0100000000000000,
    S_DIV_WAIT = 16'b1000000000000000
  } state_t;

  state_t state;
  req_t   rq;

  // cell memories
  logic   vmem [2**CELL_AW];
  point_t dmem [2**CELL_AW];
  logic [CELL_AW-1:0] addr;
  logic   vq;
  point_t dq;
  logic   vwe, vwd, dwe;
  point_t dwd;

  logic [GRID_AW-1:0] box_col_low, box_col_high, box_row_low, box_row_high;

  // scan state
  logic [1:0]               dir, nd;
  logic signed [GRID_AW+1:0] k;
  logic [3:0]               fnd;
  logic [GRID_AW-1:0]       pos [4];
  logic                     clr_rep;

  // interpolation state
  logic                     use_x, ldb;
  logic [GRID_AW-1:0]       span, d;
  logic [CELL_AW-1:0]       addr_b;
  point_t                   pa, pb;
  logic [1:0]               j;
  logic signed [32:0]       acc;
  logic                     neg;
  logic signed [15:0]       fx, fy;
  logic signed [23:0]       a_sel, b_sel;

  logic                     div_go, div_done;
  logic [DIV_W-1:0]         div_quo;
  logic [23:0]              q24, r24;

  // insert binning, truncation toward zero
  logic [GRID_AW+1:0] ins_col, ins_row;
  logic [GRID_AW-1:0] icol, irow;
  logic               ins_ok;
  logic [GRID_AW-1:0] lo, hi, xspan, yspan;
  logic               inb, xok, yok;
  logic signed [23:0] new_z;

  assign ins_col = (GRID_AW+2)'(req.coord_x >>> 8)
                 + (GRID_AW+2)'(req.coord_x[15] && (req.coord_x[7:0] != 8'd0))
                 + (GRID_AW+2)'(GRID_SIZE / 2);
  assign ins_row = (GRID_AW+2)'(req.coord_y >>> 8)
                 + (GRID_AW+2)'(req.coord_y[15] && (req.coord_y[7:0] != 8'd0))
                 + (GRID_AW+2)'(GRID_SIZE / 2);
  assign ins_ok  = (ins_col < (GRID_AW+2)'(GRID_SIZE))
                && (ins_row < (GRID_AW+2)'(GRID_SIZE));
  assign icol    = ins_col[GRID_AW-1:0];
  assign irow    = ins_row[GRID_AW-1:0];

  assign busy = (state != S_IDLE);

  assign lo  = dir[1] ? box_col_low : box_row_low;
  assign hi  = dir[1] ? box_col_high : box_row_high;
  assign inb = dir[0] ? (k <= $signed({2'b00, hi})) : (k >= $signed({2'b00, lo}));
  assign nd  = dir + 2'd1;

  assign xspan = pos[3] - pos[2];
  assign yspan = pos[1] - pos[0];
  assign xok   = fnd[3] & fnd[2];
  assign yok   = fnd[1] & fnd[0];

  assign new_z = (!vq || rq.coord_z < dq.pz) ? rq.coord_z : dq.pz;

  always_comb begin
    case (j)
      2'd0:    begin a_sel = 24'(pa.px); b_sel = 24'(pb.px); end
      2'd1:    begin a_sel = 24'(pa.py); b_sel = 24'(pb.py); end
      default: begin a_sel = pa.pz;      b_sel = pb.pz;      end
    endcase
  end

  assign q24 = div_quo[23:0];
  assign r24 = neg ? 24'(-q24) : q24;

  assign vwe    = (state == S_CLR) || (state == S_INS_WR);
  assign vwd    = (state == S_INS_WR);
  assign dwe    = (state == S_INS_WR);
  assign dwd    = '{px: rq.coord_x, py: rq.coord_y, pz: new_z};
  assign div_go = (state == S_DIV_GO);

  always_ff @(posedge clk) begin
    if (vwe) vmem[addr] <= vwd;
    vq <= vmem[addr];
  end

  always_ff @(posedge clk) begin
    if (dwe) dmem[addr] <= dwd;
    dq <= dmem[addr];
  end

  pghf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (acc[32] ? DIV_W'(-acc) : DIV_W'(acc)),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      addr         <= '0;
      clr_rep      <= 1'b0;
      done         <= 1'b0;
      box_col_low  <= GRID_AW'(GRID_SIZE - 1);
      box_row_low  <= GRID_AW'(GRID_SIZE - 1);
      box_col_high <= '0;
      box_row_high <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            rq <= req;
            unique case (req.command)
              CMD_CLEAR: begin
                addr         <= '0;
                clr_rep      <= 1'b1;
                state        <= S_CLR;
                box_col_low  <= GRID_AW'(GRID_SIZE - 1);
                box_row_low  <= GRID_AW'(GRID_SIZE - 1);
                box_col_high <= '0;
                box_row_high <= '0;
              end
              CMD_INSERT: begin
                if (ins_ok) begin
                  addr  <= {icol, irow};
                  state <= S_INS_WAIT;
                  if (icol < box_col_low)  box_col_low  <= icol;
                  if (icol > box_col_high) box_col_high <= icol;
                  if (irow < box_row_low)  box_row_low  <= irow;
                  if (irow > box_row_high) box_row_high <= irow;
                end else begin
                  done <= 1'b1;
                  rsp  <= '{status: ST_REJECTED, default: '0};
                end
              end
              CMD_QUERY: begin
                addr  <= {req.cell_col, req.cell_row};
                state <= S_Q_WAIT;
              end
              default: begin
                done <= 1'b1;
                rsp  <= '{status: ST_REJECTED, default: '0};
              end
            endcase
          end
        end
        S_CLR: begin
          addr <= addr + 1'b1;
          if (addr == '1) begin
            state <= S_IDLE;
            if (clr_rep) begin
              done <= 1'b1;
              rsp  <= '{status: ST_CLEARED, default: '0};
            end
          end
        end
        S_INS_WAIT: state <= S_INS_WR;
        S_INS_WR: begin
          state <= S_IDLE;
          done  <= 1'b1;
          rsp   <= '{status: ST_STORED, default: '0};
        end
        S_Q_WAIT: state <= S_Q_CHK;
        S_Q_CHK: begin
          if (vq) begin
            state <= S_IDLE;
            done  <= 1'b1;
            rsp   <= '{status: ST_OCCUPIED, default: '0};
          end else begin
            dir   <= 2'd0;
            fnd   <= '0;
            k     <= $signed({2'b00, rq.cell_row});
            state <= S_SC_ISS;
          end
        end
        S_SC_ISS: begin
          if (inb) begin
            addr  <= dir[1] ? {k[GRID_AW-1:0], rq.cell_row} : {rq.cell_col, k[GRID_AW-1:0]};
            state <= S_SC_WAIT;
          end else if (dir == 2'd3) begin
            state <= S_SEL;
          end else begin
            dir <= nd;
            k   <= $signed({2'b00, nd[1] ? rq.cell_col : rq.cell_row});
          end
        end
        S_SC_WAIT: state <= S_SC_CHK;
        S_SC_CHK: begin
          if (vq) begin
            fnd[dir] <= 1'b1;
            pos[dir] <= k[GRID_AW-1:0];
            if (dir == 2'd3) begin
              state <= S_SEL;
            end else begin
              dir   <= nd;
              k     <= $signed({2'b00, nd[1] ? rq.cell_col : rq.cell_row});
              state <= S_SC_ISS;
            end
          end else begin
            k     <= dir[0] ? k + 1'b1 : k - 1'b1;
            state <= S_SC_ISS;
          end
        end
        S_SEL: begin
          ldb <= 1'b0;
          if (xok && (!yok || yspan > xspan)) begin
            use_x  <= 1'b1;
            span   <= xspan;
            d      <= rq.cell_col - pos[2];
            addr   <= {pos[2], rq.cell_row};
            addr_b <= {pos[3], rq.cell_row};
            state  <= S_LD_WAIT;
          end else if (yok) begin
            use_x  <= 1'b0;
            span   <= yspan;
            d      <= rq.cell_row - pos[0];
            addr   <= {rq.cell_col, pos[0]};
            addr_b <= {rq.cell_col, pos[1]};
            state  <= S_LD_WAIT;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
            rsp   <= '{status: ST_NO_FILL, default: '0};
          end
        end
        S_LD_WAIT: state <= S_LD_CAP;
        S_LD_CAP: begin
          if (!ldb) begin
            pa    <= dq;
            addr  <= addr_b;
            ldb   <= 1'b1;
            state <= S_LD_WAIT;
          end else begin
            pb    <= dq;
            j     <= 2'd0;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          acc   <= a_sel * $signed({1'b0, GRID_AW'(span - d)});
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= acc + b_sel * $signed({1'b0, d});
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          neg   <= acc[32];
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            case (j)
              2'd0: begin
                fx    <= 16'(r24);
                j     <= 2'd1;
                state <= S_MUL1;
              end
              2'd1: begin
                fy    <= 16'(r24);
                j     <= 2'd2;
                state <= S_MUL1;
              end
              default: begin
                state <= S_IDLE;
                done  <= 1'b1;
                rsp   <= '{status: use_x ? ST_FILL_X : ST_FILL_Y,
                           fill_x: fx, fill_y: fy, fill_z: r24};
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/point_grid_hole_fill_chk.sv]
// point_grid_hole_fill_chk: port-level checks on the hole-fill grid block
// depends on pghf_pkg and point_grid_hole_fill_assert.svh; bound to the top level
`include "point_grid_hole_fill_assert.svh"

module point_grid_hole_fill_chk import pghf_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input req_t req,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  // an accepted command either answers at once or keeps the block busy
  `PGHF_ASSERT_NEXT(a_accept_busy, start && !busy, busy || done)

  // a response closes the transaction, so the block is free in that cycle
  `PGHF_ASSERT_SAME(a_done_free, done, !busy)

  `PGHF_ASSERT_SAME(a_status_code, done, rsp.status <= ST_NO_FILL)

  `PGHF_ASSERT_SAME(a_zero_unfilled, done && rsp.status != ST_FILL_X && rsp.status != ST_FILL_Y, rsp.fill_x == '0 && rsp.fill_y == '0 && rsp.fill_z == '0)

endmodule

bind point_grid_hole_fill point_grid_hole_fill_chk u_chk (.*);

[sim/pghf_checker.sv]
`timescale 1ns / 100ps
// pghf_checker: watches the command and response channels of point_grid_hole_fill,
// predicts each response from its own grid model and compares; depends on pghf_pkg
module pghf_checker import pghf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic done,
  input  rsp_t rsp,
  output int   errors,
  output int   pending
);

  bit     occupied [GRID_SIZE*GRID_SIZE];
  point_t stored   [GRID_SIZE*GRID_SIZE];
  int     col_lo, col_hi, row_lo, row_hi;
  rsp_t   expected_rsps [$];

  function automatic int cell_at(int col, int row);
    return col * GRID_SIZE + row;
  endfunction

  function automatic longint blend(longint a, longint b, longint span, longint d);
    if (span == 0) return a;
    return (a * (span - d) + b * d) / span;
  endfunction

  function automatic void empty_grid();
    foreach (occupied[i]) occupied[i] = 0;
    col_lo = GRID_SIZE - 1;
    row_lo = GRID_SIZE - 1;
    col_hi = 0;
    row_hi = 0;
  endfunction

  function automatic rsp_t grid_response(req_t r);
    rsp_t   o;
    int     x, y, z, col, row, c, rw, k, i, span, d, ym, yp, xm, xp, a, b;
    bit     use_x;
    o = '0;
    o.status = ST_REJECTED;
    case (r.command)
      CMD_CLEAR: begin
        empty_grid();
        o.status = ST_CLEARED;
      end
      CMD_INSERT: begin
        x = r.coord_x;
        y = r.coord_y;
        z = r.coord_z;
        col = x / 256 + GRID_SIZE / 2;
        row = y / 256 + GRID_SIZE / 2;
        if (col >= 0 && col < GRID_SIZE && row >= 0 && row < GRID_SIZE) begin
          i = cell_at(col, row);
          stored[i].px = r.coord_x;
          stored[i].py = r.coord_y;
          if (!occupied[i] || z < int'(stored[i].pz)) stored[i].pz = r.coord_z;
          occupied[i] = 1;
          if (col < col_lo) col_lo = col;
          if (col > col_hi) col_hi = col;
          if (row < row_lo) row_lo = row;
          if (row > row_hi) row_hi = row;
          o.status = ST_STORED;
        end
      end
      CMD_QUERY: begin
        c = r.cell_col;
        rw = r.cell_row;
        o.status = ST_NO_FILL;
        if (occupied[cell_at(c, rw)]) begin
          o.status = ST_OCCUPIED;
        end else begin
          ym = -1; yp = -1; xm = -1; xp = -1;
          for (k = rw; k >= row_lo; k--) if (occupied[cell_at(c, k)]) begin ym = k; break; end
          for (k = rw; k <= row_hi; k++) if (occupied[cell_at(c, k)]) begin yp = k; break; end
          for (k = c; k >= col_lo; k--) if (occupied[cell_at(k, rw)]) begin xm = k; break; end
          for (k = c; k <= col_hi; k++) if (occupied[cell_at(k, rw)]) begin xp = k; break; end
          use_x = xm >= 0 && xp >= 0 && (ym < 0 || yp < 0 || (yp - ym) > (xp - xm));
          if (use_x || (ym >= 0 && yp >= 0)) begin
            if (use_x) begin
              a = cell_at(xm, rw); b = cell_at(xp, rw); span = xp - xm; d = c - xm;
              o.status = ST_FILL_X;
            end else begin
              a = cell_at(c, ym); b = cell_at(c, yp); span = yp - ym; d = rw - ym;
              o.status = ST_FILL_Y;
            end
            o.fill_x = 16'(blend(stored[a].px, stored[b].px, span, d));
            o.fill_y = 16'(blend(stored[a].py, stored[b].py, span, d));
            o.fill_z = 24'(blend(stored[a].pz, stored[b].pz, span, d));
          end
        end
      end
      default: o.status = ST_REJECTED;
    endcase
    return o;
  endfunction

  initial empty_grid();

  assign pending = expected_rsps.size();

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      // a response in this cycle belongs to an older transaction than one taken now
      if (done) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response %h", $time, rsp);
          errors <= errors + 1;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status || rsp.fill_x !== want.fill_x ||
              rsp.fill_y !== want.fill_y || rsp.fill_z !== want.fill_z) begin
            $display({"%0t: mismatch expected status %0d x %0d y %0d z %0d, ",
                      "got status %0d x %0d y %0d z %0d"},
                     $time, want.status, want.fill_x, want.fill_y, want.fill_z,
                     rsp.status, rsp.fill_x, rsp.fill_y, rsp.fill_z);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) expected_rsps = {expected_rsps, grid_response(req)};
    end
  end

endmodule

[sim/tb_point_grid_hole_fill.sv]
`timescale 1ns / 100ps
// tb_point_grid_hole_fill: command stimulus and verdict for point_grid_hole_fill
// depends on pghf_pkg, the block and pghf_checker
module tb_point_grid_hole_fill;
  import pghf_pkg::*;

  localparam int STALL_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  req_t req = '0;
  logic busy, done;
  rsp_t rsp;
  int   errors, pending;
  int   idle_cycles = 0;
  bit   steady;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  point_grid_hole_fill dut (.clk(clk), .rst(rst), .start(start), .req(req),
                            .busy(busy), .done(done), .rsp(rsp));

  pghf_checker chk (.clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
                    .done(done), .rsp(rsp), .errors(errors), .pending(pending));

  // watchdog: nothing taken and nothing returned for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("point_grid_hole_fill test failed");
      $finish;
    end
  end

  task automatic send(req_t r);
    int gap, n;
    start <= 1;
    req <= r;
    do @(posedge clk); while (busy);
    gap = 0;
    if (!steady) begin
      n = $urandom_range(0, 99);
      if (n < 60) gap = 0;
      else if (n < 95) gap = $urandom_range(1, 4);
      else gap = $urandom_range(10, 300);
    end
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic req_t noise();
    req_t r;
    r = req_t'({$urandom, $urandom});
    return r;
  endfunction

  function automatic req_t put(int col, int row, int z);
    req_t r;
    r = noise();
    r.command = CMD_INSERT;
    r.coord_x = 16'((col - GRID_SIZE / 2) * 256 + $urandom_range(0, 255));
    r.coord_y = 16'((row - GRID_SIZE / 2) * 256 + $urandom_range(0, 255));
    r.coord_z = 24'(z);
    return r;
  endfunction

  function automatic req_t ask(int col, int row);
    req_t r;
    r = noise();
    r.command = CMD_QUERY;
    r.cell_col = 8'(col);
    r.cell_row = 8'(row);
    return r;
  endfunction

  function automatic req_t op(logic [1:0] code);
    req_t r;
    r = noise();
    r.command = code;
    return r;
  endfunction

  function automatic req_t raw_insert(int x, int y, int z);
    req_t r;
    r = op(CMD_INSERT);
    r.coord_x = 16'(x);
    r.coord_y = 16'(y);
    r.coord_z = 24'(z);
    return r;
  endfunction

  initial begin
    req_t r;
    int   phase, k, n, items, lo;
    repeat (4) @(posedge clk);
    rst <= 0;
    steady = 1;

    // directed
    send(op(CMD_CLEAR));
    send(raw_insert(-32768, -32768, -8388608));
    send(raw_insert(32767, 32767, 8388607));
    send(raw_insert(32767, 32767, 8388600));
    send(raw_insert(32767, 32767, 8388607));
    send(raw_insert(-1, -255, 5));
    send(raw_insert(-256, 255, -5));
    send(ask(255, 255));
    send(ask(128, 128));
    send(op(CMD_UNUSED));
    send(put(10, 5, 1000));
    send(put(20, 5, -3000));
    send(ask(15, 5));
    send(put(40, 30, 77));
    send(put(40, 50, -77));
    send(ask(40, 41));
    send(put(38, 41, 9));
    send(put(44, 41, 11));
    send(ask(40, 41));
    send(ask(200, 3));
    send(op(CMD_CLEAR));
    send(ask(5, 5));
    send(put(100, 100, 1));
    send(ask(0, 100));

    steady = 0;
    for (phase = 0; phase < 6; phase++) begin
      items = (phase == 5) ? 150 : 330;
      lo = $urandom_range(100, 140);
      steady = (phase == 2);
      for (k = 0; k < items; k++) begin
        n = $urandom_range(0, 99);
        if (n < 45) r = put(lo + $urandom_range(0, 15), lo + $urandom_range(0, 15),
                            $signed($urandom_range(0, 16777215)) - 8388608);
        else if (n < 93) r = ask(lo + $urandom_range(0, 15), lo + $urandom_range(0, 15));
        else if (n < 96) r = op(CMD_UNUSED);
        else if (phase == 5) r = op(CMD_INSERT);
        else r = ask($urandom_range(0, 255), $urandom_range(0, 255));
        send(r);
      end
      if (phase == 3) begin
        start <= 0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      send(op(CMD_CLEAR));
    end

    start <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("point_grid_hole_fill test passed");
    end else begin
      $display("point_grid_hole_fill test failed");
    end
    $finish;
  end

endmodule
